### sv/tta_pkg.sv
`default_nettype none

package tta_pkg;

  // Default build values for the top-level parameters.
  localparam int unsigned RADIUS_DEF      = 4;
  localparam int unsigned SAMPLE_BITS_DEF = 8;

  // Fixed field widths of the stream and configuration ports.
  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned THR_W       = 8;
  localparam int unsigned NB_NUM      = 8;
  localparam int unsigned CNT_W       = 4;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned TDATA_IN_W  = SAMPLE_W * (NB_NUM + 1) + NB_NUM;

  // Numerator: nine samples plus the rounding half of the divisor fit in 12 bits.
  localparam int unsigned NUM_W = 12;

  // The divide by 2..9 runs as a multiply by a rounded-up reciprocal.
  localparam int unsigned RECIP_W     = 20;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned PROD_W      = NUM_W + RECIP_W;

  // Register reset values.
  localparam logic [THR_W-1:0] LUMA_THR_RST   = 8'd4;
  localparam logic [THR_W-1:0] CHROMA_THR_RST = 8'd8;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LUMA_THR   = 8'd0,
    REG_CHROMA_THR = 8'd1
  } cfg_reg_e;

  // One input pixel position as it enters the pipeline.
  typedef struct packed {
    logic [SAMPLE_W-1:0]              center;
    logic [NB_NUM-1:0][SAMPLE_W-1:0]  nb;
    logic [NB_NUM-1:0]                enable;
    logic                             chroma;
  } pix_t;

  // After the threshold stage: what each neighbor adds, and how many count.
  typedef struct packed {
    logic [SAMPLE_W-1:0]              center;
    logic [NB_NUM-1:0][SAMPLE_W-1:0]  addend;
    logic [CNT_W-1:0]                 count;
  } sel_t;

  // After the adder stage: rounded numerator ready for the divide.
  typedef struct packed {
    logic [SAMPLE_W-1:0] center;
    logic [NUM_W-1:0]    num;
    logic [CNT_W-1:0]    count;
  } sum_t;

  // ceil(2^20 / (count + 1)) for count 1..8; exact for numerators below 2^12.
  function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] count);
    logic [RECIP_W-1:0] r;
    unique case (count)
      4'd1:    r = 20'd524288;
      4'd2:    r = 20'd349526;
      4'd3:    r = 20'd262144;
      4'd4:    r = 20'd209716;
      4'd5:    r = 20'd174763;
      4'd6:    r = 20'd149797;
      4'd7:    r = 20'd131072;
      4'd8:    r = 20'd116509;
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### sv/tta_select.sv
`default_nettype none

module tta_select #(
  parameter int unsigned RADIUS      = tta_pkg::RADIUS_DEF,
  parameter int unsigned SAMPLE_BITS = tta_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire tta_pkg::pix_t              in_pix_i,
  input  wire logic [tta_pkg::THR_W-1:0]  luma_thr_i,
  input  wire logic [tta_pkg::THR_W-1:0]  chroma_thr_i,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output tta_pkg::sel_t                   out_sel_o
);

  localparam int unsigned LIM_W = tta_pkg::THR_W + SAMPLE_BITS;
  localparam int unsigned SCL_W = 2 * tta_pkg::SAMPLE_W;

  logic [tta_pkg::THR_W-1:0]                     thr;
  logic [LIM_W-1:0]                              limit;
  logic [tta_pkg::NB_NUM-1:0]                    nb_use;
  logic [tta_pkg::NB_NUM-1:0][tta_pkg::SAMPLE_W-1:0] diff;
  logic [tta_pkg::NB_NUM-1:0][SCL_W-1:0]         diff_scl;
  tta_pkg::sel_t                                 sel_d, sel_q;
  logic                                          valid_q;

  // Active threshold scaled to the sample range: thr * (2^SAMPLE_BITS - 1).
  assign thr   = in_pix_i.chroma ? chroma_thr_i : luma_thr_i;
  assign limit = {thr, {SAMPLE_BITS{1'b0}}} - LIM_W'(thr);

  // Per neighbor: enabled, inside the radius, and a nonzero threshold.
  always_comb begin
    sel_d.center = in_pix_i.center;
    sel_d.count  = '0;
    for (int k = 0; k < tta_pkg::NB_NUM; k++) begin
      nb_use[k] = in_pix_i.enable[k] && (((k & 3) + 1) <= RADIUS) && (thr != '0);
      diff[k]   = (in_pix_i.nb[k] > in_pix_i.center) ?
                  (in_pix_i.nb[k] - in_pix_i.center) : (in_pix_i.center - in_pix_i.nb[k]);
      diff_scl[k] = {diff[k], {tta_pkg::SAMPLE_W{1'b0}}} - SCL_W'(diff[k]);
      if (!nb_use[k]) begin
        sel_d.addend[k] = '0;
      end else if (LIM_W'(diff_scl[k]) <= limit) begin
        sel_d.addend[k] = in_pix_i.nb[k];
      end else begin
        sel_d.addend[k] = in_pix_i.center;
      end
      sel_d.count = sel_d.count + tta_pkg::CNT_W'(nb_use[k]);
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sel_q <= sel_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_sel_o   = sel_q;

endmodule

`default_nettype wire

### sv/tta_sum.sv
`default_nettype none

module tta_sum (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire tta_pkg::sel_t  in_sel_i,
  output logic                out_valid_o,
  input  wire logic           out_ready_i,
  output tta_pkg::sum_t       out_sum_o
);

  tta_pkg::sum_t sum_d, sum_q;
  logic          valid_q;
  logic [tta_pkg::CNT_W-1:0] div;

  // Sum of center and all addends, plus half the divisor for round half up.
  assign div = in_sel_i.count + tta_pkg::CNT_W'(1);

  always_comb begin
    sum_d.center = in_sel_i.center;
    sum_d.count  = in_sel_i.count;
    sum_d.num    = tta_pkg::NUM_W'(in_sel_i.center) + tta_pkg::NUM_W'(div >> 1);
    for (int k = 0; k < tta_pkg::NB_NUM; k++) begin
      sum_d.num = sum_d.num + tta_pkg::NUM_W'(in_sel_i.addend[k]);
    end
  end

  assign in_ready_o = !valid_q || out_ready_i;

  // Stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Stage payload.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      sum_q <= sum_d;
    end
  end

  assign out_valid_o = valid_q;
  assign out_sum_o   = sum_q;

endmodule

`default_nettype wire

### sv/tta_divide.sv
`default_nettype none

module tta_divide (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire tta_pkg::sum_t                 in_sum_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [tta_pkg::SAMPLE_W-1:0]       out_sample_o
);

  logic                               mul_valid_q;
  logic                               mul_ready;
  logic [tta_pkg::PROD_W-1:0]         prod_q;
  logic [tta_pkg::SAMPLE_W-1:0]       center_q;
  logic                               bypass_q;
  logic                               res_valid_q;
  logic [tta_pkg::SAMPLE_W-1:0]       res_d, res_q;

  assign in_ready_o = !mul_valid_q || mul_ready;
  assign mul_ready  = !res_valid_q || out_ready_i;

  // Multiply stage valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      mul_valid_q <= in_valid_i;
    end
  end

  // Numerator times reciprocal of the divisor; no neighbor counted passes center.
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      prod_q   <= tta_pkg::PROD_W'(in_sum_i.num) *
                  tta_pkg::PROD_W'(tta_pkg::recip(in_sum_i.count));
      center_q <= in_sum_i.center;
      bypass_q <= (in_sum_i.count == '0);
    end
  end

  // The average of in-range samples never exceeds the sample maximum, so the
  // quotient already sits in the field and needs no further clamp.
  assign res_d = bypass_q ? center_q :
                 prod_q[tta_pkg::RECIP_SHIFT +: tta_pkg::SAMPLE_W];

  // Output register valid bit.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (mul_ready) begin
      res_valid_q <= mul_valid_q;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (mul_valid_q && mul_ready) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o  = res_valid_q;
  assign out_sample_o = res_q;

endmodule

`default_nettype wire

### sv/temporal_threshold_average.sv
// Pipeline: an accepted input beat is registered in turn by threshold select,
// adder tree, reciprocal multiply and output register before its output beat.
// Throughput: one beat per cycle; each stage holds its beat while the next one stalls.
// Reset: asynchronous, active low; clears all stage valid bits and sets the
// luma and chroma thresholds to 4 and 8.
`default_nettype none

module temporal_threshold_average #(
  parameter int unsigned RADIUS      = tta_pkg::RADIUS_DEF,
  parameter int unsigned SAMPLE_BITS = tta_pkg::SAMPLE_BITS_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Fields from bit 0: center_sample, prev_sample_1..4, next_sample_1..4, neighbor_enable.
  input  wire logic [tta_pkg::TDATA_IN_W-1:0]    s_axis_tdata,
  // Fields from bit 0: use_chroma_threshold.
  input  wire logic                              s_axis_tuser,
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // Fields from bit 0: filtered_sample.
  output logic [tta_pkg::SAMPLE_W-1:0]           m_axis_tdata,
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [tta_pkg::CFG_INDEX_W-1:0]   cfg_index_i,
  input  wire logic [tta_pkg::THR_W-1:0]         cfg_data_i
);

  logic [tta_pkg::THR_W-1:0] luma_thr_q, chroma_thr_q;
  tta_pkg::pix_t             pix;
  logic                      sel_valid, sel_ready;
  tta_pkg::sel_t             sel;
  logic                      sum_valid, sum_ready;
  tta_pkg::sum_t             sum;

  // Configuration writes are always taken.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      luma_thr_q   <= tta_pkg::LUMA_THR_RST;
      chroma_thr_q <= tta_pkg::CHROMA_THR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        tta_pkg::REG_LUMA_THR:   luma_thr_q   <= cfg_data_i;
        tta_pkg::REG_CHROMA_THR: chroma_thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the input beat.
  always_comb begin
    pix.center = s_axis_tdata[tta_pkg::SAMPLE_W-1:0];
    for (int k = 0; k < tta_pkg::NB_NUM; k++) begin
      pix.nb[k] = s_axis_tdata[tta_pkg::SAMPLE_W*(k+1) +: tta_pkg::SAMPLE_W];
    end
    pix.enable = s_axis_tdata[tta_pkg::SAMPLE_W*(tta_pkg::NB_NUM+1) +: tta_pkg::NB_NUM];
    pix.chroma = s_axis_tuser;
  end

  tta_select #(
    .RADIUS      (RADIUS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_select (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_pix_i     (pix),
    .luma_thr_i   (luma_thr_q),
    .chroma_thr_i (chroma_thr_q),
    .out_valid_o  (sel_valid),
    .out_ready_i  (sel_ready),
    .out_sel_o    (sel)
  );

  tta_sum u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sel_valid),
    .in_ready_o  (sel_ready),
    .in_sel_i    (sel),
    .out_valid_o (sum_valid),
    .out_ready_i (sum_ready),
    .out_sum_o   (sum)
  );

  tta_divide u_divide (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (sum_valid),
    .in_ready_o   (sum_ready),
    .in_sum_i     (sum),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_sample_o (m_axis_tdata)
  );

`ifndef SYNTHESIS
  // Input stalls only when every stage is full and the output is blocked.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (sel_valid && sum_valid && m_axis_tvalid && !m_axis_tready))
    else $error("input stalled while the pipeline has room");

  // The neighbor count never exceeds the neighbors inside the radius.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    sel_valid |-> (int'(sel.count) <= 2 * int'(RADIUS)))
    else $error("neighbor count beyond radius");

  // With no neighbor counted the numerator is the center sample alone.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sum_valid && (sum.count == '0)) |-> (sum.num == tta_pkg::NUM_W'(sum.center)))
    else $error("numerator differs from center with no neighbor");
`endif

endmodule

`default_nettype wire
